FILE: rtl/pcxd_pkg.sv
// Package for the PCX 1-bit run-length decoder.
// Shared types, result codes and header constants; no dependencies.
package pcxd_pkg;

    // Decoder phase within one file
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_SKIP   = 2'd2
    } phase_t;

    // Result kinds (carried on tuser)
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_HDR  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_BAD_ID    = 3'd0;
    localparam logic [2:0] ERR_NOT_MONO  = 3'd1;
    localparam logic [2:0] ERR_ORIGIN    = 3'd2;
    localparam logic [2:0] ERR_HDR_SHORT = 3'd3;
    localparam logic [2:0] ERR_RUN_CUT   = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd5;

    // Header layout and constants
    localparam logic [6:0] HDR_LAST_IDX  = 7'd127;
    localparam logic [6:0] IDX_ID        = 7'd0;
    localparam logic [6:0] IDX_COMP      = 7'd2;
    localparam logic [6:0] IDX_BPP       = 7'd3;
    localparam logic [6:0] IDX_MINX_LO   = 7'd4;
    localparam logic [6:0] IDX_MINY_HI   = 7'd7;
    localparam logic [6:0] IDX_MAXY_LO   = 7'd10;
    localparam logic [6:0] IDX_MAXY_HI   = 7'd11;
    localparam logic [6:0] IDX_PLANES    = 7'd65;
    localparam logic [6:0] IDX_BPL_LO    = 7'd66;
    localparam logic [6:0] IDX_BPL_HI    = 7'd67;
    localparam logic [7:0] PCX_ID        = 8'h0A;
    localparam logic [7:0] COMP_RLE      = 8'd1;
    localparam logic [1:0] RUN_MARK      = 2'b11;

    // Multiplier: one step per bit of bytes-per-line
    localparam int MUL_STEPS = 16;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

    localparam int TDATA_W = 80;

    // Header status seen by the sequencer
    typedef struct packed {
        logic        at_last;   // next header byte is the final one
        logic        bad;       // header check failed
        logic [2:0]  err_code;
        logic        rle_on;
        logic [15:0] bpl;
        logic [16:0] rows;
    } hdr_stat_t;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [31:0] byte_offset;
        logic [15:0] row_bytes;
        logic [16:0] row_count;
        logic [2:0]  error_code;
        logic        last;
    } result_t;

endpackage

FILE: rtl/pcxd_hdr.sv
// Header capture and check for the PCX decoder.
// Holds the header byte index and captured fields; uses pcxd_pkg.
module pcxd_hdr (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cap,     // header byte accepted
    input  logic               clr,     // return to reset values
    input  logic [7:0]         hbyte,
    output pcxd_pkg::hdr_stat_t stat
);

    logic [6:0]  idx_reg,    idx_next;
    logic [7:0]  id_reg,     id_next;
    logic [7:0]  comp_reg,   comp_next;
    logic [7:0]  bpp_reg,    bpp_next;
    logic [7:0]  planes_reg, planes_next;
    logic        orgnz_reg,  orgnz_next;
    logic [15:0] maxy_reg,   maxy_next;
    logic [15:0] bpl_reg,    bpl_next;

    // Field capture by header index
    always_comb
    begin
        idx_next    = idx_reg;
        id_next     = id_reg;
        comp_next   = comp_reg;
        bpp_next    = bpp_reg;
        planes_next = planes_reg;
        orgnz_next  = orgnz_reg;
        maxy_next   = maxy_reg;
        bpl_next    = bpl_reg;
        if (clr)
        begin
            idx_next    = '0;
            id_next     = '0;
            comp_next   = '0;
            bpp_next    = '0;
            planes_next = '0;
            orgnz_next  = 1'b0;
            maxy_next   = '0;
            bpl_next    = '0;
        end
        else if (cap)
        begin
            case (idx_reg)
                pcxd_pkg::IDX_ID:      id_next = hbyte;
                pcxd_pkg::IDX_COMP:    comp_next = hbyte;
                pcxd_pkg::IDX_BPP:     bpp_next = hbyte;
                pcxd_pkg::IDX_MAXY_LO: maxy_next = {maxy_reg[15:8], hbyte};
                pcxd_pkg::IDX_MAXY_HI: maxy_next = {hbyte, maxy_reg[7:0]};
                pcxd_pkg::IDX_PLANES:  planes_next = hbyte;
                pcxd_pkg::IDX_BPL_LO:  bpl_next = {bpl_reg[15:8], hbyte};
                pcxd_pkg::IDX_BPL_HI:  bpl_next = {hbyte, bpl_reg[7:0]};
                default:
                begin
                    // min_x and min_y bytes only matter as nonzero
                    if (idx_reg inside {[pcxd_pkg::IDX_MINX_LO:pcxd_pkg::IDX_MINY_HI]}
                        && hbyte != 8'd0)
                        orgnz_next = 1'b1;
                end
            endcase
            if (idx_reg != pcxd_pkg::HDR_LAST_IDX)
                idx_next = idx_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            id_reg     <= '0;
            comp_reg   <= '0;
            bpp_reg    <= '0;
            planes_reg <= '0;
            orgnz_reg  <= 1'b0;
            maxy_reg   <= '0;
            bpl_reg    <= '0;
        end
        else
        begin
            idx_reg    <= idx_next;
            id_reg     <= id_next;
            comp_reg   <= comp_next;
            bpp_reg    <= bpp_next;
            planes_reg <= planes_next;
            orgnz_reg  <= orgnz_next;
            maxy_reg   <= maxy_next;
            bpl_reg    <= bpl_next;
        end
    end

    // Header check, first failing rule wins
    always_comb
    begin
        stat.at_last  = (idx_reg == pcxd_pkg::HDR_LAST_IDX);
        stat.rle_on   = (comp_reg == pcxd_pkg::COMP_RLE);
        stat.bpl      = bpl_reg;
        stat.rows     = {1'b0, maxy_reg} + 17'd1;
        stat.bad      = 1'b1;
        stat.err_code = pcxd_pkg::ERR_BAD_ID;
        if (id_reg != pcxd_pkg::PCX_ID)
            stat.err_code = pcxd_pkg::ERR_BAD_ID;
        else if (!(bpp_reg == 8'd1 && planes_reg == 8'd1))
            stat.err_code = pcxd_pkg::ERR_NOT_MONO;
        else if (orgnz_reg)
            stat.err_code = pcxd_pkg::ERR_ORIGIN;
        else
            stat.bad = 1'b0;
    end

endmodule

FILE: rtl/pcxd_mul.sv
// Shift-add multiplier for the image size, one bit per cycle.
// Product is truncated to 32 bits; uses pcxd_pkg.
module pcxd_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] mplier,
    input  logic [16:0] mcand,
    output logic        busy,
    output logic [31:0] product
);

    logic [pcxd_pkg::MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] mc_reg,  mc_next;
    logic [15:0] mp_reg,  mp_next;

    // One add-and-shift step per cycle
    always_comb
    begin
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        mc_next  = mc_reg;
        mp_next  = mp_reg;
        if (start)
        begin
            cnt_next = pcxd_pkg::MUL_CNT_W'(pcxd_pkg::MUL_STEPS);
            acc_next = '0;
            mc_next  = {15'd0, mcand};
            mp_next  = mplier;
        end
        else if (cnt_reg != '0)
        begin
            if (mp_reg[0])
                acc_next = acc_reg + mc_reg;
            mc_next  = {mc_reg[30:0], 1'b0};
            mp_next  = {1'b0, mp_reg[15:1]};
            cnt_next = cnt_reg - pcxd_pkg::MUL_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign busy    = (cnt_reg != '0);
    assign product = acc_reg;

endmodule

FILE: rtl/pcxd_obuf.sv
// Output register for decoder results, packs the stream fields.
// Uses pcxd_pkg result type.
module pcxd_obuf (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  pcxd_pkg::result_t               res,
    output logic                            slot_free,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // data_byte[7:0], byte_offset[39:8], row_bytes[55:40], row_count[72:56],
    // error_code[75:73], zero fill[79:76]
    output logic [pcxd_pkg::TDATA_W-1:0]    m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);

    logic              valid_reg, valid_next;
    pcxd_pkg::result_t res_reg;

    assign slot_free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
            valid_next = 1'b1;
        else if (m_axis_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, loaded on each request
    always_ff @(posedge clk)
    begin
        if (push)
            res_reg <= res;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'd0, res_reg.error_code, res_reg.row_count,
                            res_reg.row_bytes, res_reg.byte_offset, res_reg.data_byte};
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = res_reg.last;

endmodule

FILE: rtl/pcx_1bit_rle_decoder.sv
// PCX 1-bit run-length decoder, top level and sequencer.
// Uses pcxd_pkg, pcxd_hdr, pcxd_mul and pcxd_obuf.
//
// Input stream: one file byte per request on s_axis_tdata, s_axis_tlast on
// the final byte of a file. Bytes 0..127 are the header; byte 127 triggers
// the header check and one "header accepted" or error result. Later bytes
// are decoded (run-length when compression is 1) into data results, each
// tagged with its image offset. Result kind travels on m_axis_tuser, the
// final result caused by one input byte carries m_axis_tlast.
// Flow: s_axis_tready is high only while the sequencer is idle. A header
// byte or a run prefix is only accepted; a literal byte is accepted, then
// loaded into the output register; the byte after a prefix with count n
// gives n copies (none when n is zero), one output register load per copy.
// The good header result is followed by 16 shift-add steps, then the load
// of the image size, before data is taken. A file that ends without error adds a done result.
// When the receiver stalls, the sequencer holds in its current step until
// the output register frees, so no result is dropped. Reset clears all
// file state and the output register valid; the block then waits for a
// header.
module pcx_1bit_rle_decoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // file_byte[7:0]
    input  logic [7:0]                   s_axis_tdata,
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // data_byte[7:0], byte_offset[39:8], row_bytes[55:40], row_count[72:56],
    // error_code[75:73], zero fill[79:76]
    output logic [pcxd_pkg::TDATA_W-1:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                   m_axis_tuser,
    output logic                         m_axis_tlast
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_RUN   = 6'b001000,
        ST_ERR   = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    pcxd_pkg::phase_t    phase_reg, phase_next;
    logic [31:0]         space_reg, space_next;
    logic [31:0]         offset_reg, offset_next;
    logic [5:0]          pend_reg, pend_next;
    logic                pflag_reg, pflag_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [7:0]          byte_reg, byte_next;
    logic                eof_reg, eof_next;
    logic [2:0]          err_reg, err_next;

    logic                accept;
    logic                clr;
    logic                hdr_cap;
    logic                push;
    logic                slot_free;
    logic                mul_start;
    logic                mul_busy;
    logic [31:0]         mul_product;
    pcxd_pkg::hdr_stat_t hstat;
    pcxd_pkg::result_t   res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    pcxd_hdr u_hdr (
        .clk   (clk),
        .rst_n (rst_n),
        .cap   (hdr_cap),
        .clr   (clr),
        .hbyte (s_axis_tdata),
        .stat  (hstat)
    );

    pcxd_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mplier  (hstat.bpl),
        .mcand   (hstat.rows),
        .busy    (mul_busy),
        .product (mul_product)
    );

    pcxd_obuf u_obuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .res           (res),
        .slot_free     (slot_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        space_next  = space_reg;
        offset_next = offset_reg;
        pend_next   = pend_reg;
        pflag_next  = pflag_reg;
        cnt_next    = cnt_reg;
        byte_next   = byte_reg;
        eof_next    = eof_reg;
        err_next    = err_reg;
        clr         = 1'b0;
        hdr_cap     = 1'b0;
        push        = 1'b0;
        mul_start   = 1'b0;
        res         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    byte_next = s_axis_tdata;
                    eof_next  = s_axis_tlast;
                    case (phase_reg)
                        pcxd_pkg::PH_HEADER:
                        begin
                            hdr_cap = 1'b1;
                            if (hstat.at_last)
                                state_next = ST_CHECK;
                            else if (s_axis_tlast)
                            begin
                                err_next   = pcxd_pkg::ERR_HDR_SHORT;
                                state_next = ST_ERR;
                            end
                        end
                        pcxd_pkg::PH_DATA:
                        begin
                            if (pflag_reg)
                            begin
                                // byte after a run prefix
                                cnt_next   = pend_reg;
                                pflag_next = 1'b0;
                                pend_next  = '0;
                                state_next = ST_RUN;
                            end
                            else if (hstat.rle_on && s_axis_tdata[7:6] == pcxd_pkg::RUN_MARK)
                            begin
                                pend_next  = s_axis_tdata[5:0];
                                pflag_next = 1'b1;
                                if (s_axis_tlast)
                                begin
                                    err_next   = pcxd_pkg::ERR_RUN_CUT;
                                    state_next = ST_ERR;
                                end
                            end
                            else
                            begin
                                cnt_next   = 6'd1;
                                state_next = ST_RUN;
                            end
                        end
                        default:
                        begin
                            // skipping to end of file
                            if (s_axis_tlast)
                                clr = 1'b1;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (slot_free)
                begin
                    push = 1'b1;
                    if (hstat.bad)
                    begin
                        res.kind       = pcxd_pkg::KIND_ERR;
                        res.error_code = hstat.err_code;
                        res.last       = 1'b1;
                        phase_next     = pcxd_pkg::PH_SKIP;
                        clr            = eof_reg;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        res.kind      = pcxd_pkg::KIND_HDR;
                        res.row_bytes = hstat.bpl;
                        res.row_count = hstat.rows;
                        res.last      = !eof_reg;
                        phase_next    = pcxd_pkg::PH_DATA;
                        if (eof_reg)
                            state_next = ST_FIN;
                        else
                        begin
                            mul_start  = 1'b1;
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                if (!mul_busy)
                begin
                    space_next  = mul_product;
                    offset_next = '0;
                    state_next  = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == '0)
                    state_next = eof_reg ? ST_FIN : ST_IDLE;
                else if (slot_free)
                begin
                    push = 1'b1;
                    if (space_reg == '0)
                    begin
                        res.kind       = pcxd_pkg::KIND_ERR;
                        res.error_code = pcxd_pkg::ERR_OVERFLOW;
                        res.last       = 1'b1;
                        phase_next     = pcxd_pkg::PH_SKIP;
                        clr            = eof_reg;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        res.kind        = pcxd_pkg::KIND_DATA;
                        res.data_byte   = byte_reg;
                        res.byte_offset = offset_reg;
                        res.last        = (cnt_reg == 6'd1) && !eof_reg;
                        space_next      = space_reg - 32'd1;
                        offset_next     = offset_reg + 32'd1;
                        cnt_next        = cnt_reg - 6'd1;
                        if (cnt_reg == 6'd1)
                            state_next = eof_reg ? ST_FIN : ST_IDLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (slot_free)
                begin
                    push           = 1'b1;
                    res.kind       = pcxd_pkg::KIND_ERR;
                    res.error_code = err_reg;
                    res.last       = 1'b1;
                    clr            = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    push       = 1'b1;
                    res.kind   = pcxd_pkg::KIND_DONE;
                    res.last   = 1'b1;
                    clr        = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // End of file: back to header phase
        if (clr)
        begin
            phase_next  = pcxd_pkg::PH_HEADER;
            space_next  = '0;
            offset_next = '0;
            pend_next   = '0;
            pflag_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= pcxd_pkg::PH_HEADER;
            space_reg  <= '0;
            offset_reg <= '0;
            pend_reg   <= '0;
            pflag_reg  <= 1'b0;
            cnt_reg    <= '0;
            eof_reg    <= 1'b0;
            err_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            space_reg  <= space_next;
            offset_reg <= offset_next;
            pend_reg   <= pend_next;
            pflag_reg  <= pflag_next;
            cnt_reg    <= cnt_next;
            eof_reg    <= eof_next;
            err_reg    <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    // Checks

    // A data result always consumes one unit of image space
    a_space_dec: assert property (@(posedge clk) disable iff (!rst_n)
        push && res.kind == pcxd_pkg::KIND_DATA && !clr
        |=> space_reg == $past(space_reg) - 32'd1)
        else $error("space not decremented on data result");

    // No data result once the image is full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && res.kind == pcxd_pkg::KIND_DATA |-> space_reg != '0)
        else $error("data result with no space left");

    // A pending run prefix exists only in the data phase
    a_pend_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pflag_reg |-> phase_reg == pcxd_pkg::PH_DATA)
        else $error("run prefix pending outside data phase");

    // The size multiply only runs right after a good header
    a_mul_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> phase_reg == pcxd_pkg::PH_DATA && !pflag_reg)
        else $error("multiply outside header acceptance");

endmodule
